@@ sv/analog_keypad_event_debouncer_unit_macros.svh @@
// Assertion macros used by the checker file of the keypad debouncer.
`ifndef ANALOG_KEYPAD_EVENT_DEBOUNCER_UNIT_MACROS_SVH
`define ANALOG_KEYPAD_EVENT_DEBOUNCER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AKEDU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad debouncer check failed");

// Next-cycle implication, off while reset is asserted.
`define AKEDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad debouncer check failed");

`endif

@@ sv/akedu_pkg.sv @@
// Types, constants and register codes of the keypad event debouncer.
package akedu_pkg;

    localparam int NUM_LEVELS        = 6;
    localparam int LEVEL_W           = 10;
    localparam int TIME_W            = 32;
    localparam int MS_W              = 16;
    localparam int KEY_W             = 3;
    localparam int KIND_W            = 3;
    localparam int CHECK_INTERVAL_MS = 5;
    localparam int DIST_LIMIT        = 1023;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_LEVEL_NO_KEY     = 3'd0;
    localparam logic [2:0] REG_LEVEL_FORWARD    = 3'd1;
    localparam logic [2:0] REG_LEVEL_TURN_LEFT  = 3'd2;
    localparam logic [2:0] REG_LEVEL_GO         = 3'd3;
    localparam logic [2:0] REG_LEVEL_TURN_RIGHT = 3'd4;
    localparam logic [2:0] REG_LEVEL_BACKWARD   = 3'd5;
    localparam logic [2:0] REG_DEBOUNCE_MS      = 3'd6;
    localparam logic [2:0] REG_LONG_PRESS_MS    = 3'd7;

    // Event codes
    localparam logic [KIND_W-1:0] EV_NONE          = 3'd0;
    localparam logic [KIND_W-1:0] EV_PRESSED       = 3'd1;
    localparam logic [KIND_W-1:0] EV_LONG_PRESSED  = 3'd2;
    localparam logic [KIND_W-1:0] EV_RELEASED      = 3'd3;
    localparam logic [KIND_W-1:0] EV_LONG_RELEASED = 3'd4;

    localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;

    localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [MS_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [LEVEL_W-1:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [KEY_W-1:0]  key_id;
    } t_out_item;

    // Classified tick handed from front to back
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [KEY_W-1:0]  key;
    } t_cls_item;

    typedef struct packed {
        logic [NUM_LEVELS-1:0][LEVEL_W-1:0] level;
        logic [MS_W-1:0]                    debounce_ms;
        logic [MS_W-1:0]                    long_press_ms;
    } t_cfg;

endpackage

@@ sv/akedu_front.sv @@
// Front end: accepts readings and picks the nearest reference level.
module akedu_front
    import akedu_pkg::*;
(
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    input  t_cfg      i_cfg,
    input  logic      i_q_ready,
    output logic      o_q_push,
    output t_cls_item o_q_data
);

    logic [LEVEL_W-1:0] best;
    logic [LEVEL_W-1:0] gap;
    logic [KEY_W-1:0]   key;

    // Nearest level, lowest index wins a tie, nothing at or beyond the limit
    always_comb begin
        best = LEVEL_W'(DIST_LIMIT);
        key  = KEY_NONE;
        gap  = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i_cfg.level[i] > i_in_data.adc_sample) begin
                gap = i_cfg.level[i] - i_in_data.adc_sample;
            end else begin
                gap = i_in_data.adc_sample - i_cfg.level[i];
            end
            if (gap < best) begin
                best = gap;
                key  = KEY_W'(i);
            end
        end
    end

    // Push the classified tick when the queue has room
    assign o_in_ready      = i_q_ready;
    assign o_q_push        = i_in_valid && i_q_ready;
    assign o_q_data.now_ms = i_in_data.now_ms;
    assign o_q_data.key    = key;

endmodule

@@ sv/akedu_queue.sv @@
// Short queue that decouples classification from the event state machine.
module akedu_queue
    import akedu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_push_data,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cls_item o_data
);

    t_cls_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/akedu_back.sv @@
// Back end: debounce timing, press tracking and the output register.
module akedu_back
    import akedu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cls_item i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [1:0] {
        HELD_OFF,
        HELD_ON,
        HELD_STALLED
    } t_held;

    t_held              r_held, n_held;
    logic [TIME_W-1:0]  r_last_check, n_last_check;
    logic [KEY_W-1:0]   r_read_key, n_read_key;
    logic [KEY_W-1:0]   r_latched, n_latched;
    logic [TIME_W-1:0]  r_stamp_recent, n_stamp_recent;
    logic [TIME_W-1:0]  r_stamp_press, n_stamp_press;
    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic [TIME_W-1:0]  since_check;
    logic [TIME_W-1:0]  since_gate;
    logic [TIME_W-1:0]  since_press;
    logic               now_on;
    logic               step;
    logic               cleared;

    // Pop when the output register is free or being emptied
    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Elapsed times for the interval, debounce and long-press checks
    assign now_on      = (r_read_key != KEY_NONE);
    assign since_check = i_q_data.now_ms - r_last_check;
    assign since_gate  = i_q_data.now_ms - (now_on ? r_stamp_press : r_stamp_recent);
    assign since_press = i_q_data.now_ms - r_stamp_press;
    assign step        = since_check > TIME_W'(CHECK_INTERVAL_MS);
    assign cleared     = since_gate > {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms};

    always_comb begin
        n_held         = r_held;
        n_last_check   = r_last_check;
        n_read_key     = r_read_key;
        n_latched      = r_latched;
        n_stamp_recent = r_stamp_recent;
        n_stamp_press  = r_stamp_press;
        n_out.event_kind = EV_NONE;
        n_out.key_id     = KEY_NONE;
        if (step) begin
            // Once the debounce time has passed, take a fresh reading; a different key while latched reads as none
            if (cleared) begin
                n_read_key = i_q_data.key;
                if (i_q_data.key != KEY_NONE && r_latched != KEY_NONE &&
                    i_q_data.key != r_latched) begin
                    n_read_key = KEY_NONE;
                end
            end
            case (r_held)
                HELD_OFF: begin
                    if (n_read_key != KEY_NONE) begin
                        n_latched        = n_read_key;
                        n_stamp_press    = i_q_data.now_ms;
                        n_held           = HELD_ON;
                        n_out.event_kind = EV_PRESSED;
                        n_out.key_id     = n_read_key;
                    end
                end
                HELD_ON: begin
                    n_stamp_recent = i_q_data.now_ms;
                    if (n_read_key != KEY_NONE) begin
                        if (since_press > {{(TIME_W-MS_W){1'b0}}, i_cfg.long_press_ms}) begin
                            n_held           = HELD_STALLED;
                            n_out.event_kind = EV_LONG_PRESSED;
                            n_out.key_id     = r_latched;
                        end
                    end else begin
                        n_held           = HELD_OFF;
                        n_out.event_kind = EV_RELEASED;
                        n_out.key_id     = r_latched;
                        n_latched        = KEY_NONE;
                    end
                end
                HELD_STALLED: begin
                    if (n_read_key == KEY_NONE) begin
                        n_stamp_recent   = i_q_data.now_ms;
                        n_held           = HELD_OFF;
                        n_out.event_kind = EV_LONG_RELEASED;
                        n_out.key_id     = r_latched;
                        n_latched        = KEY_NONE;
                    end
                end
                default: begin
                    n_held = r_held;
                end
            endcase
            n_last_check = i_q_data.now_ms;
        end
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= HELD_OFF;
            r_last_check   <= '0;
            r_read_key     <= KEY_NONE;
            r_latched      <= KEY_NONE;
            r_stamp_recent <= '0;
            r_stamp_press  <= '0;
            r_out_valid    <= 1'b0;
        end else if (o_q_pop) begin
            r_held         <= n_held;
            r_last_check   <= n_last_check;
            r_read_key     <= n_read_key;
            r_latched      <= n_latched;
            r_stamp_recent <= n_stamp_recent;
            r_stamp_press  <= n_stamp_press;
            r_out_valid    <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid    <= 1'b0;
        end
    end

    // Load the result payload on each processed tick
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

endmodule

@@ sv/analog_keypad_event_debouncer_unit.sv @@
// Top level of the resistor-ladder keypad event debouncer.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one tick per
// transaction: a millisecond timestamp and a 10-bit keypad reading.
// Output channel (o_out_valid / i_out_ready / o_out_data) gives exactly one
// result per tick: an event code and the key it concerns, or none.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high; levels 0..5, then debounce and long-press times. Write only when idle.
// Path: classification into a two-entry queue at the accepting edge, then
// the state update of the back end into the output register.
// Throughput: one tick per cycle while the receiver takes results; the state
// update of the back end is the loop that sets that rate.
// Reset clears the queue, the press state and all timestamps; levels go to
// zero, debounce to 50 ms and long press to 1000 ms.
// When the receiver stalls the result is held; the queue absorbs two more
// ticks before o_in_ready drops.
module analog_keypad_event_debouncer_unit
    import akedu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [MS_W-1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    t_cfg      r_cfg;
    logic      q_ready;
    logic      q_push;
    t_cls_item q_push_data;
    logic      q_valid;
    logic      q_pop;
    t_cls_item q_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level         <= '0;
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LEVEL_NO_KEY:     r_cfg.level[0] <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_FORWARD:    r_cfg.level[1] <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_TURN_LEFT:  r_cfg.level[2] <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_GO:         r_cfg.level[3] <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_TURN_RIGHT: r_cfg.level[4] <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_BACKWARD:   r_cfg.level[5] <= i_cfg_data[LEVEL_W-1:0];
                REG_DEBOUNCE_MS:      r_cfg.debounce_ms <= i_cfg_data;
                REG_LONG_PRESS_MS:    r_cfg.long_press_ms <= i_cfg_data;
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    akedu_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_push_data)
    );

    akedu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_ready     (q_ready),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    akedu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/akedu_checker.sv @@
// Port-level checks for the keypad debouncer, bound to the top level.
`include "analog_keypad_event_debouncer_unit_macros.svh"

module akedu_checker
    import akedu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [2:0] i_cfg_index,
    input logic [MS_W-1:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_item   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out_data
);

    // A stalled result stays put
    `AKEDU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // Only defined event codes leave the block
    `AKEDU_ASSERT_IMPLY(a_kind_range, i_clk, i_rst_n, o_out_valid, o_out_data.event_kind == EV_NONE || o_out_data.event_kind == EV_PRESSED || o_out_data.event_kind == EV_LONG_PRESSED || o_out_data.event_kind == EV_RELEASED || o_out_data.event_kind == EV_LONG_RELEASED)

    // Every real event names a key, and no event names none
    `AKEDU_ASSERT_IMPLY(a_kind_key, i_clk, i_rst_n, o_out_valid, (o_out_data.event_kind == EV_NONE) == (o_out_data.key_id == KEY_NONE))

endmodule

bind analog_keypad_event_debouncer_unit akedu_checker u_akedu_checker (.*);
